@@ rtl/gcde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcde_pkg
// Shared types and codes for the greatest common divisor core.
// ----------------------------------------------------------------------------
package gcde_pkg;

  // Default operand width.
  localparam int OPERAND_BITS_DEF = 31;

  // Datapath operation codes, driven by the sequencer.
  typedef logic [2:0] op_t;
  localparam op_t OP_HOLD       = 3'd0;
  localparam op_t OP_LOAD       = 3'd1;
  localparam op_t OP_HALVE_BOTH = 3'd2;
  localparam op_t OP_HALVE_A    = 3'd3;
  localparam op_t OP_HALVE_B    = 3'd4;
  localparam op_t OP_SUB        = 3'd5;
  localparam op_t OP_SWAP       = 3'd6;
  localparam op_t OP_DOUBLE_B   = 3'd7;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    logic k_inc;
    logic k_dec;
    logic emit;
    logic emit_sel_a;
  } ctrl_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_odd;
    logic b_odd;
    logic a_lt_b;
    logic k_zero;
  } status_t;

endpackage

@@ rtl/gcd_euclid_modulo_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_euclid_modulo_core
// Greatest common divisor of two unsigned operands, zero when both are zero.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Handshake
//   -------   ---------------------------------   ------------------------------
//   input     in_value_a, in_value_b              taken when start & !busy
//   result    out_divisor                         one-cycle strobe out_valid
//
// Busy stays high for a data-dependent time: an item with a zero operand ends
// at the zero check, the others run through the binary reduction below. The
// strobe rises in the same cycle that busy falls. The datapath, with its single
// shared subtractor, performs at most one subtract, swap or shift step per
// cycle, as the sequencer directs.
// Reset (synchronous, active low) returns the sequencer to idle and drops the
// strobe; operand registers are not reset. The receiver cannot stall, so each
// result is shown for exactly one cycle, in the cycle busy falls.
//
// The result equals Euclid's remainder rule. The core computes it with the
// binary method: common factors of two are counted, b is made odd, then a is
// repeatedly halved or replaced by (a - b) / 2, swapping when a < b, until a
// reaches zero; the answer is b shifted back up by the common power of two.
// ----------------------------------------------------------------------------
module gcd_euclid_modulo_core #(
  parameter int OPERAND_BITS = gcde_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] in_value_a,
  input  logic [OPERAND_BITS-1:0] in_value_b,
  output logic                    out_valid,
  output logic [OPERAND_BITS-1:0] out_divisor
);

  // Count of common factors of two; never reaches OPERAND_BITS.
  localparam int K_W = $clog2(OPERAND_BITS);

  logic [OPERAND_BITS-1:0] a_r;
  logic [OPERAND_BITS-1:0] a_nxt;
  logic [OPERAND_BITS-1:0] b_r;
  logic [OPERAND_BITS-1:0] b_nxt;
  logic [K_W-1:0]          k_r;
  logic [K_W-1:0]          k_nxt;
  logic [OPERAND_BITS-1:0] divisor_r;
  logic                    valid_r;

  logic [OPERAND_BITS-1:0] diff;
  logic                    a_lt_b;
  logic                    a_zero;
  logic                    b_zero;

  gcde_pkg::ctrl_t   ctrl;
  gcde_pkg::status_t status;

  // Shared arithmetic unit.
  gcde_sub_unit #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_sub (
    .a      (a_r),
    .b      (b_r),
    .diff   (diff),
    .a_lt_b (a_lt_b),
    .a_zero (a_zero),
    .b_zero (b_zero)
  );

  // Sequencer.
  gcde_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  always_comb begin
    status.a_zero = a_zero;
    status.b_zero = b_zero;
    status.a_odd  = a_r[0];
    status.b_odd  = b_r[0];
    status.a_lt_b = a_lt_b;
    status.k_zero = (k_r == '0);
  end

  // Operand datapath: apart from the load, every step is one subtract, swap or single-bit shift.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    case (ctrl.op)
      gcde_pkg::OP_LOAD: begin
        a_nxt = in_value_a;
        b_nxt = in_value_b;
      end
      gcde_pkg::OP_HALVE_BOTH: begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
      end
      gcde_pkg::OP_HALVE_A: begin
        a_nxt = a_r >> 1;
      end
      gcde_pkg::OP_HALVE_B: begin
        b_nxt = b_r >> 1;
      end
      gcde_pkg::OP_SUB: begin
        // Both are odd here, so the difference is even.
        a_nxt = diff >> 1;
      end
      gcde_pkg::OP_SWAP: begin
        a_nxt = b_r;
        b_nxt = a_r;
      end
      gcde_pkg::OP_DOUBLE_B: begin
        b_nxt = b_r << 1;
      end
      default: begin
        a_nxt = a_r;
        b_nxt = b_r;
      end
    endcase
  end

  always_comb begin
    k_nxt = k_r;
    if (ctrl.op == gcde_pkg::OP_LOAD) begin
      k_nxt = '0;
    end else if (ctrl.k_inc) begin
      k_nxt = k_r + 1'b1;
    end else if (ctrl.k_dec) begin
      k_nxt = k_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    if (ctrl.emit) begin
      divisor_r <= ctrl.emit_sel_a ? a_r : b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl.emit;
    end
  end

  assign out_valid   = valid_r;
  assign out_divisor = divisor_r;

endmodule

@@ rtl/gcde_sub_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcde_sub_unit
// Shared subtract and compare unit: a - b, borrow and zero tests.
// ----------------------------------------------------------------------------
module gcde_sub_unit #(
  parameter int OPERAND_BITS = gcde_pkg::OPERAND_BITS_DEF
) (
  input  logic [OPERAND_BITS-1:0] a,
  input  logic [OPERAND_BITS-1:0] b,
  output logic [OPERAND_BITS-1:0] diff,
  output logic                    a_lt_b,
  output logic                    a_zero,
  output logic                    b_zero
);

  logic [OPERAND_BITS:0] full_diff;

  assign full_diff = {1'b0, a} - {1'b0, b};
  assign diff      = full_diff[OPERAND_BITS-1:0];
  assign a_lt_b    = full_diff[OPERAND_BITS];
  assign a_zero    = (a == '0);
  assign b_zero    = (b == '0);

endmodule

@@ rtl/gcde_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcde_ctrl
// Sequencer for the binary reduction: zero check, common twos, odd reduction
// and restoration of the common power of two.
// ----------------------------------------------------------------------------
module gcde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gcde_pkg::status_t status,
  output gcde_pkg::ctrl_t   ctrl,
  output logic              busy
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_STRIP2  = 3'd2;
  localparam logic [2:0] ST_STRIPB  = 3'd3;
  localparam logic [2:0] ST_REDUCE  = 3'd4;
  localparam logic [2:0] ST_RESTORE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt       = state_r;
    ctrl.op         = gcde_pkg::OP_HOLD;
    ctrl.k_inc      = 1'b0;
    ctrl.k_dec      = 1'b0;
    ctrl.emit       = 1'b0;
    ctrl.emit_sel_a = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.op   = gcde_pkg::OP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A zero operand means the other one is the answer.
        if (status.a_zero) begin
          ctrl.emit = 1'b1;
          state_nxt = ST_IDLE;
        end else if (status.b_zero) begin
          ctrl.emit       = 1'b1;
          ctrl.emit_sel_a = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_STRIP2;
        end
      end
      ST_STRIP2: begin
        if (status.a_odd || status.b_odd) begin
          state_nxt = ST_STRIPB;
        end else begin
          ctrl.op    = gcde_pkg::OP_HALVE_BOTH;
          ctrl.k_inc = 1'b1;
        end
      end
      ST_STRIPB: begin
        if (status.b_odd) begin
          state_nxt = ST_REDUCE;
        end else begin
          ctrl.op = gcde_pkg::OP_HALVE_B;
        end
      end
      ST_REDUCE: begin
        // b stays odd here; a shrinks until it reaches zero.
        if (status.a_zero) begin
          state_nxt = ST_RESTORE;
        end else if (!status.a_odd) begin
          ctrl.op = gcde_pkg::OP_HALVE_A;
        end else if (status.a_lt_b) begin
          ctrl.op = gcde_pkg::OP_SWAP;
        end else begin
          ctrl.op = gcde_pkg::OP_SUB;
        end
      end
      ST_RESTORE: begin
        if (status.k_zero) begin
          ctrl.emit = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctrl.op    = gcde_pkg::OP_DOUBLE_B;
          ctrl.k_dec = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
